// ===== hdl/bspline_basis_evaluator_macros.svh =====
// Assertion macros shared by the B-spline basis evaluator modules.
// The macros assume a clock named clock and a synchronous reset named reset.
`ifndef BSPLINE_BASIS_EVALUATOR_MACROS_SVH
`define BSPLINE_BASIS_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBE_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bbe_pkg.sv =====
// Package for the B-spline basis evaluator: widths, constants and the
// divider command and status types. No dependencies.
`timescale 1ns / 1ps

package bbe_pkg;

   localparam int MAX_KNOTS  = 64;
   localparam int MAX_DEGREE = 8;

   localparam int KNOT_AW    = $clog2(MAX_KNOTS);
   localparam int CNT_W      = $clog2(MAX_KNOTS + 1);
   localparam int DEG_W      = $clog2(MAX_DEGREE + 1);

   localparam int CFG_DEG_W  = 4;
   localparam int CFG_KC_W   = 7;
   localparam int CSR_W      = 7;
   localparam int CSR_AW     = 1;

   localparam int KIDX_W     = 6;
   localparam int KNOT_W     = 32;
   localparam int ROW_W      = 6;
   localparam int BASIS_W    = 31;

   localparam int NB_W       = 34;
   localparam int DIFF_W     = KNOT_W + 1;
   localparam int DEN_W      = DIFF_W + 1;

   localparam logic signed [NB_W-1:0] UNIT_Q30 = NB_W'(64'sd1 <<< 30);
   localparam logic signed [NB_W-1:0] Q_MAX    = NB_W'(64'sd1 <<< 32);
   localparam logic signed [NB_W-1:0] Q_MIN    = -Q_MAX;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_DEGREE     = 1'b0,
      CSR_KNOT_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                     start;
      logic signed [NB_W-1:0]   a;
      logic signed [DIFF_W-1:0] x;
      logic signed [DEN_W-1:0]  d;
   } sdiv_cmd_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic signed [NB_W-1:0] q;
   } sdiv_stat_type;

endpackage

// ===== hdl/bbe_ifs.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on bbe_pkg.
`timescale 1ns / 1ps

interface bbe_req_if import bbe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [KIDX_W-1:0]        knot_index;
   logic signed [KNOT_W-1:0] knot_value;
   logic signed [KNOT_W-1:0] point;

   modport source (output valid, output opcode, output knot_index, output knot_value,
                   output point, input ready);
   modport sink   (input valid, input opcode, input knot_index, input knot_value,
                   input point, output ready);
endinterface

interface bbe_rsp_if import bbe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   row;
   logic [BASIS_W-1:0] basis_value;
   logic               last;

   modport source (output valid, output row, output basis_value, output last, input ready);
   modport sink   (input valid, input row, input basis_value, input last, output ready);
endinterface

// ===== hdl/bspline_basis_evaluator.sv =====
// Top level of the B-spline basis evaluator: knot RAM, span search and
// Cox-de Boor sequencer. Depends on bbe_pkg, bbe_ifs, bbe_ram and bbe_sdiv.
`timescale 1ns / 1ps
`include "bspline_basis_evaluator_macros.svh"

// Usage:
// Requests arrive as valid/ready beats on req_bus. A write beat stores one knot
// into the 64-entry knot RAM. An evaluate beat takes a point, clamps it to the
// end spans, finds the span by binary search over the RAM (one read port) and
// runs the triangular recurrence on one shared scaled divider, two divisions
// per term with a nonzero denominator. It then sends degree+1 beats on rsp_bus
// (degree capped at 8), row and basis value, with last set on the final beat,
// or none when there are fewer than degree+2 knots. Requests are taken one at
// a time. Degree and knot count are to be written through csr_write_en,
// csr_index and csr_wdata only while the block is idle; the block itself does
// not enforce this. Reset sets degree 3 and knot count 8 and leaves the knot
// RAM undefined until written. When the receiver stalls, the pending beat holds
// in the output register and the sequencer waits.

module bspline_basis_evaluator import bbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bbe_req_if.sink           req_bus,
   bbe_rsp_if.source         rsp_bus,
   input  logic              csr_write_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   typedef enum logic [10:0] {
      T_IDLE   = 11'b00000000001,
      T_HI     = 11'b00000000010,
      T_LO     = 11'b00000000100,
      T_BS_ISS = 11'b00000001000,
      T_BS_CMP = 11'b00000010000,
      T_LD_ISS = 11'b00000100000,
      T_LD_CAP = 11'b00001000000,
      T_TERM   = 11'b00010000000,
      T_WA     = 11'b00100000000,
      T_WB     = 11'b01000000000,
      T_EMIT   = 11'b10000000000
   } ctl_state_type;

   ctl_state_type            state_ff, state_in;
   logic [CFG_DEG_W-1:0]     degree_ff;
   logic [CFG_KC_W-1:0]      knot_count_ff;
   logic [DEG_W-1:0]         p_ff, p_in;
   logic signed [KNOT_W-1:0] u_ff, u_in;
   logic [KNOT_AW-1:0]       lo_ff, lo_in;
   logic [KNOT_AW-1:0]       hi_ff, hi_in;
   logic [KNOT_AW-1:0]       mid_ff, mid_in;
   logic [KNOT_AW-1:0]       span_ff, span_in;
   logic [DEG_W-1:0]         j_ff, j_in;
   logic [DEG_W-1:0]         r_ff, r_in;
   logic                     side_ff, side_in;
   logic signed [NB_W-1:0]   saved_ff, saved_in;
   logic signed [NB_W-1:0]   ta_ff, ta_in;
   logic signed [DEN_W-1:0]  d_ff, d_in;
   logic signed [DIFF_W-1:0] lft_ff [MAX_DEGREE+1];
   logic signed [DIFF_W-1:0] lft_in [MAX_DEGREE+1];
   logic signed [DIFF_W-1:0] rgt_ff [MAX_DEGREE+1];
   logic signed [DIFF_W-1:0] rgt_in [MAX_DEGREE+1];
   logic signed [NB_W-1:0]   nb_ff  [MAX_DEGREE+1];
   logic signed [NB_W-1:0]   nb_in  [MAX_DEGREE+1];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]         rsp_row_ff, rsp_row_in;
   logic [BASIS_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     knot_we;
   logic [KNOT_AW-1:0]       rd_addr;
   logic [KNOT_W-1:0]        knot_q;
   logic signed [KNOT_W-1:0] knot_s;
   logic [DEG_W-1:0]         p_eff;
   logic [CNT_W-1:0]         kc_eff;
   logic                     no_basis;
   logic [KNOT_AW-1:0]       n1_eff;
   logic [KNOT_AW:0]         lohi_sum;
   logic [DEG_W-1:0]         r1_idx;
   logic [DEG_W-1:0]         jr_idx;
   logic signed [DIFF_W-1:0] rgt_sel;
   logic signed [DIFF_W-1:0] lft_sel;
   logic signed [NB_W-1:0]   nb_sel;
   logic signed [DEN_W-1:0]  d_now;
   logic                     upd_en;
   logic signed [NB_W-1:0]   upd_ta;
   logic signed [NB_W-1:0]   upd_tb;
   logic signed [NB_W:0]     upd_sum;
   logic signed [NB_W-1:0]   upd_sat;
   logic                     out_free;
   logic                     out_load;
   logic signed [NB_W-1:0]   clamp_v;
   sdiv_cmd_type             div_cmd;
   sdiv_stat_type            div_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= CFG_DEG_W'(3);
         knot_count_ff <= CFG_KC_W'(8);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEGREE:     degree_ff     <= csr_wdata[CFG_DEG_W-1:0];
            CSR_KNOT_COUNT: knot_count_ff <= csr_wdata[CFG_KC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept  = req_bus.valid && req_bus.ready;
   assign knot_we = accept && (opcode_type'(req_bus.opcode) == OP_WRITE) &&
                    (int'(req_bus.knot_index) < MAX_KNOTS);

   bbe_ram #(
      .WIDTH (KNOT_W),
      .DEPTH (MAX_KNOTS)
   ) u_knot_ram (
      .clock (clock),
      .we    (knot_we),
      .waddr (KNOT_AW'(req_bus.knot_index)),
      .wdata (req_bus.knot_value),
      .raddr (rd_addr),
      .rdata (knot_q)
   );

   bbe_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_stat (div_stat)
   );

   assign knot_s   = $signed(knot_q);
   assign p_eff    = (int'(degree_ff) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree_ff);
   assign kc_eff   = (int'(knot_count_ff) > MAX_KNOTS) ? CNT_W'(MAX_KNOTS)
                                                      : CNT_W'(knot_count_ff);
   assign no_basis = ({1'b0, kc_eff} < ((CNT_W+1)'(p_eff) + (CNT_W+1)'(2)));
   assign n1_eff   = KNOT_AW'(kc_eff - CNT_W'(p_eff) - CNT_W'(1));
   assign lohi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   assign r1_idx  = r_ff + 1'b1;
   assign jr_idx  = j_ff - r_ff;
   assign rgt_sel = rgt_ff[r1_idx];
   assign lft_sel = lft_ff[jr_idx];
   assign nb_sel  = nb_ff[r_ff];
   assign d_now   = DEN_W'(rgt_sel) + DEN_W'(lft_sel);

   assign upd_sum = (NB_W+1)'(saved_ff) + (NB_W+1)'(upd_ta);
   assign upd_sat = (upd_sum > Q_MAX) ? Q_MAX : ((upd_sum < Q_MIN) ? Q_MIN : NB_W'(upd_sum));

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign clamp_v  = (nb_sel < 0) ? '0 : ((nb_sel > UNIT_Q30) ? UNIT_Q30 : nb_sel);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      u_in         = u_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      span_in      = span_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      side_in      = side_ff;
      saved_in     = saved_ff;
      ta_in        = ta_ff;
      d_in         = d_ff;
      lft_in       = lft_ff;
      rgt_in       = rgt_ff;
      nb_in        = nb_ff;
      rd_addr      = lo_ff;
      div_cmd      = '0;
      upd_en       = 1'b0;
      upd_ta       = '0;
      upd_tb       = '0;
      out_load     = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         T_IDLE: begin
            rd_addr = n1_eff;
            if (accept && (opcode_type'(req_bus.opcode) == OP_EVAL) && !no_basis) begin
               p_in     = p_eff;
               u_in     = req_bus.point;
               hi_in    = n1_eff;
               lo_in    = KNOT_AW'(p_eff);
               j_in     = DEG_W'(1);
               state_in = T_HI;
            end
         end
         T_HI: begin
            rd_addr = lo_ff;
            if (u_ff >= knot_s) begin
               span_in  = hi_ff - 1'b1;
               state_in = T_LD_ISS;
            end else begin
               state_in = T_LO;
            end
         end
         T_LO: begin
            if (u_ff <= knot_s) begin
               span_in  = lo_ff;
               state_in = T_LD_ISS;
            end else begin
               state_in = T_BS_ISS;
            end
         end
         T_BS_ISS: begin
            rd_addr = lohi_sum[KNOT_AW:1];
            if ((hi_ff - lo_ff) > KNOT_AW'(1)) begin
               mid_in   = lohi_sum[KNOT_AW:1];
               state_in = T_BS_CMP;
            end else begin
               span_in  = lo_ff;
               state_in = T_LD_ISS;
            end
         end
         T_BS_CMP: begin
            if (u_ff < knot_s) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
            end
            state_in = T_BS_ISS;
         end
         T_LD_ISS: begin
            rd_addr   = side_ff ? (span_ff + KNOT_AW'(j_ff))
                                : (span_ff + 1'b1 - KNOT_AW'(j_ff));
            nb_in[0]  = UNIT_Q30;
            if (p_ff == '0) begin
               r_in     = '0;
               state_in = T_EMIT;
            end else begin
               state_in = T_LD_CAP;
            end
         end
         T_LD_CAP: begin
            side_in = !side_ff;
            if (!side_ff) begin
               lft_in[j_ff] = DIFF_W'(u_ff) - DIFF_W'(knot_s);
            end else begin
               rgt_in[j_ff] = DIFF_W'(knot_s) - DIFF_W'(u_ff);
               if (j_ff == p_ff) begin
                  j_in     = DEG_W'(1);
                  r_in     = '0;
                  saved_in = '0;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
            state_in = (side_ff && (j_ff == p_ff)) ? T_TERM : T_LD_ISS;
         end
         T_TERM: begin
            d_in = d_now;
            if (d_now == '0) begin
               upd_en = 1'b1;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.a     = nb_sel;
               div_cmd.x     = rgt_sel;
               div_cmd.d     = d_now;
               state_in      = T_WA;
            end
         end
         T_WA: begin
            if (div_stat.done) begin
               ta_in         = div_stat.q;
               div_cmd.start = 1'b1;
               div_cmd.a     = nb_sel;
               div_cmd.x     = lft_sel;
               div_cmd.d     = d_ff;
               state_in      = T_WB;
            end
         end
         T_WB: begin
            if (div_stat.done) begin
               upd_en = 1'b1;
               upd_ta = ta_ff;
               upd_tb = div_stat.q;
            end
         end
         T_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_row_in   = ROW_W'(span_ff) - ROW_W'(p_ff) + ROW_W'(r_ff);
               rsp_value_in = BASIS_W'(clamp_v);
               rsp_last_in  = (r_ff == p_ff);
               r_in         = r_ff + 1'b1;
               if (r_ff == p_ff) begin
                  state_in = T_IDLE;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase

      if (upd_en) begin
         nb_in[r_ff] = upd_sat;
         saved_in    = upd_tb;
         if (r1_idx == j_ff) begin
            nb_in[j_ff] = upd_tb;
            r_in        = '0;
            saved_in    = '0;
            if (j_ff == p_ff) begin
               state_in = T_EMIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = T_TERM;
            end
         end else begin
            r_in     = r_ff + 1'b1;
            state_in = T_TERM;
         end
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         side_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
      end
      p_ff         <= p_in;
      u_ff         <= u_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      span_ff      <= span_in;
      j_ff         <= j_in;
      r_ff         <= r_in;
      saved_ff     <= saved_in;
      ta_ff        <= ta_in;
      d_ff         <= d_in;
      lft_ff       <= lft_in;
      rgt_ff       <= rgt_in;
      nb_ff        <= nb_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_bus.ready       = (state_ff == T_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.row         = rsp_row_ff;
   assign rsp_bus.basis_value = rsp_value_ff;
   assign rsp_bus.last        = rsp_last_ff;

   `BBE_ASSERT_IMPL(a_div_start_idle, div_cmd.start, !div_stat.busy, "Divider started while busy.")
   `BBE_ASSERT_NEXT(a_div_not_instant, div_cmd.start, !div_stat.done, "Divider finished too early.")
   `BBE_ASSERT_IMPL(a_out_no_overwrite, out_load, !rsp_valid_ff || rsp_bus.ready, "Pending beat overwritten.")

endmodule

// ===== hdl/bbe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bbe_sdiv.sv =====
// Scaled divider: round(a*x/d) with ties away from zero, saturated to +-2^32.
// Split multiply over D_MUL0 and D_MUL1, then one quotient bit per cycle. Depends on bbe_pkg.
`timescale 1ns / 1ps
`include "bspline_basis_evaluator_macros.svh"

module bbe_sdiv import bbe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sdiv_cmd_type  div_cmd,
   output sdiv_stat_type div_stat
);

   localparam int MA_W   = NB_W - 1;
   localparam int MX_W   = DIFF_W - 1;
   localparam int MD_W   = DEN_W;
   localparam int LO_W   = 16;
   localparam int PROD_W = MA_W + MX_W;
   localparam int CNT_W_D = $clog2(MD_W);
   localparam logic [MD_W-1:0] LIM = MD_W'(Q_MAX);

   typedef enum logic [5:0] {
      D_IDLE = 6'b000001,
      D_MUL0 = 6'b000010,
      D_MUL1 = 6'b000100,
      D_PRE  = 6'b001000,
      D_DIV  = 6'b010000,
      D_FIN  = 6'b100000
   } sdiv_state_type;

   sdiv_state_type         state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [MA_W-1:0]        ma_ff, ma_in;
   logic [MX_W-1:0]        mx_ff, mx_in;
   logic [MD_W-1:0]        md_ff, md_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [MD_W-1:0]        rem_ff, rem_in;
   logic [MD_W-1:0]        qsh_ff, qsh_in;
   logic [CNT_W_D-1:0]     cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic signed [NB_W-1:0] q_ff, q_in;

   logic [NB_W-1:0]          a_mag;
   logic [DIFF_W-1:0]        x_mag;
   logic [DEN_W-1:0]         d_mag;
   logic [LO_W+MX_W-1:0]     prod_lo;
   logic [PROD_W-LO_W-1:0]   prod_hi;
   logic [MD_W-1:0]          top_part;
   logic [MD_W:0]            trial;
   logic [MD_W:0]            trial_sub;
   logic                     trial_ge;
   logic [MD_W-1:0]          mag_sat;

   assign a_mag   = div_cmd.a[NB_W-1] ? $unsigned(-div_cmd.a) : $unsigned(div_cmd.a);
   assign x_mag   = div_cmd.x[DIFF_W-1] ? $unsigned(-div_cmd.x) : $unsigned(div_cmd.x);
   assign d_mag   = div_cmd.d[DEN_W-1] ? $unsigned(-div_cmd.d) : $unsigned(div_cmd.d);
   assign prod_lo = ma_ff[LO_W-1:0] * mx_ff;
   assign prod_hi = ma_ff[MA_W-1:LO_W] * mx_ff;
   assign top_part = MD_W'(acc_ff[PROD_W-1:MD_W]);
   assign trial     = {rem_ff, qsh_ff[MD_W-1]};
   assign trial_sub = trial - {1'b0, md_ff};
   assign trial_ge  = trial >= {1'b0, md_ff};
   assign mag_sat   = (qsh_ff > LIM) ? LIM : qsh_ff;

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      ma_in    = ma_ff;
      mx_in    = mx_ff;
      md_in    = md_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      qsh_in   = qsh_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      q_in     = q_ff;
      case (state_ff)
         D_IDLE: begin
            if (div_cmd.start) begin
               neg_in   = div_cmd.a[NB_W-1] ^ div_cmd.x[DIFF_W-1] ^ div_cmd.d[DEN_W-1];
               ma_in    = a_mag[MA_W-1:0];
               mx_in    = x_mag[MX_W-1:0];
               md_in    = d_mag;
               state_in = D_MUL0;
            end
         end
         D_MUL0: begin
            acc_in   = PROD_W'(prod_lo) + PROD_W'(md_ff >> 1);
            state_in = D_MUL1;
         end
         D_MUL1: begin
            acc_in   = acc_ff + {prod_hi, {LO_W{1'b0}}};
            state_in = D_PRE;
         end
         D_PRE: begin
            if (top_part >= md_ff) begin
               q_in     = neg_ff ? Q_MIN : Q_MAX;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               rem_in   = top_part;
               qsh_in   = acc_ff[MD_W-1:0];
               cnt_in   = '0;
               state_in = D_DIV;
            end
         end
         D_DIV: begin
            rem_in = trial_ge ? trial_sub[MD_W-1:0] : trial[MD_W-1:0];
            qsh_in = {qsh_ff[MD_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W_D'(MD_W - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            q_in     = neg_ff ? -$signed(mag_sat) : $signed(mag_sat);
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mx_ff  <= mx_in;
      md_ff  <= md_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   assign div_stat.busy = (state_ff != D_IDLE);
   assign div_stat.done = done_ff;
   assign div_stat.q    = q_ff;

   `BBE_ASSERT_IMPL(a_rem_below_divisor, state_ff == D_DIV, rem_ff < md_ff, "Partial remainder reached the divisor.")
   `BBE_ASSERT_IMPL(a_quotient_in_range, done_ff, (q_ff <= Q_MAX) && (q_ff >= Q_MIN), "Quotient outside the saturation range.")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for bspline_basis_evaluator: knot writes and point evaluations
// checked beat by beat against a fixed-point Cox-de Boor predictor in this file.
// Depends on bbe_pkg, bbe_ifs and the evaluator RTL.
`timescale 1ns / 1ps

module tb;
   import bbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint UNIT = 64'sd1 <<< 30;
   localparam longint WIDE = 64'sd1 <<< 32;

   typedef struct {
      logic [ROW_W-1:0]   row;
      logic [BASIS_W-1:0] value;
      logic               last;
   } basis_beat_type;

   typedef struct {
      opcode_type        op;
      logic [KIDX_W-1:0] idx;
      logic [31:0]       kval;
      logic [31:0]       pt;
      bit                zero_span;
      int                row0;
   } stim_row_type;

   typedef struct {
      int deg;
      int kc;
      int items;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = CSR_DEGREE;
   logic [CSR_W-1:0] csr_wdata = '0;

   bbe_req_if req_bus ();
   bbe_rsp_if rsp_bus ();

   bspline_basis_evaluator dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   longint knots [MAX_KNOTS];
   int deg_reg = 3;
   int kc_reg = 8;
   basis_beat_type pending_basis[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;

   function automatic longint knot_at(longint k);
      if (k < 0 || k >= MAX_KNOTS) return 0;
      return knots[k];
   endfunction

   function automatic longint clamp_wide(longint v);
      if (v > WIDE) return WIDE;
      if (v < -WIDE) return -WIDE;
      return v;
   endfunction

   function automatic longint round_ratio(longint a, longint x, longint d);
      bit neg;
      longint unsigned ma, mx, md, q;
      neg = ((a < 0) != (x < 0)) != (d < 0);
      ma = a < 0 ? -a : a;
      mx = x < 0 ? -x : x;
      md = d < 0 ? -d : d;
      if (ma == 0 || mx == 0) return 0;
      q = (ma * mx + md / 2) / md;
      if (q > WIDE) q = WIDE;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint locate_span(longint n, longint p, longint u);
      longint lo, hi, mid;
      lo = p;
      hi = n + 1;
      if (u >= knot_at(n + 1)) return n;
      if (u <= knot_at(p)) return p;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (u < knot_at(mid)) hi = mid;
         else lo = mid;
      end
      return lo;
   endfunction

   function automatic void predict_basis(logic signed [31:0] point);
      longint p, kc, n, span, u, saved, d, ta, tb, v;
      longint nb [MAX_DEGREE+1];
      longint lft [MAX_DEGREE+1];
      longint rgt [MAX_DEGREE+1];
      basis_beat_type b;
      p = deg_reg > MAX_DEGREE ? MAX_DEGREE : deg_reg;
      kc = kc_reg > MAX_KNOTS ? MAX_KNOTS : kc_reg;
      n = kc - p - 2;
      if (n < 0) return;
      u = point;
      span = locate_span(n, p, u);
      nb[0] = UNIT;
      for (int j = 1; j <= p; j++) begin
         saved = 0;
         lft[j] = u - knot_at(span + 1 - j);
         rgt[j] = knot_at(span + j) - u;
         for (int r = 0; r < j; r++) begin
            d = rgt[r+1] + lft[j-r];
            ta = 0;
            tb = 0;
            if (d != 0) begin
               ta = round_ratio(nb[r], rgt[r+1], d);
               tb = round_ratio(nb[r], lft[j-r], d);
            end
            nb[r] = clamp_wide(saved + ta);
            saved = tb;
         end
         nb[j] = saved;
      end
      for (int r = 0; r <= p; r++) begin
         v = nb[r];
         if (v < 0) v = 0;
         if (v > UNIT) v = UNIT;
         b.row = ROW_W'(span - p + r);
         b.value = BASIS_W'(v);
         b.last = (r == p);
         pending_basis.push_back(b);
      end
   endfunction

   task automatic send_beat(stim_row_type s);
      basis_beat_type b;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= s.op;
      req_bus.knot_index <= s.idx;
      req_bus.knot_value <= s.kval;
      req_bus.point <= s.pt;
      do @(posedge clock); while (!req_bus.ready);
      if (s.zero_span) begin
         for (int r = 0; r < 4; r++) begin
            b.row = ROW_W'(s.row0 + r);
            b.value = '0;
            b.last = (r == 3);
            pending_basis.push_back(b);
         end
      end else if (s.op == OP_WRITE) begin
         knots[s.idx] = longint'(signed'(s.kval));
      end else begin
         predict_basis(s.pt);
      end
   endtask

   task automatic settle_and_configure(int deg, int kc);
      req_bus.valid <= 1'b0;
      while (pending_basis.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_DEGREE;
      csr_wdata <= CSR_W'(deg);
      @(posedge clock);
      csr_index <= CSR_KNOT_COUNT;
      csr_wdata <= CSR_W'(kc);
      @(posedge clock);
      csr_write_en <= 1'b0;
      deg_reg = deg;
      kc_reg = kc;
   endtask

   function automatic stim_row_type random_item();
      stim_row_type s;
      longint p, n, lo, hi;
      int idx;
      s.zero_span = 1'b0;
      s.row0 = 0;
      s.kval = $urandom;
      s.pt = $urandom;
      idx = $urandom_range(0, MAX_KNOTS - 1);
      s.idx = KIDX_W'(idx);
      p = deg_reg > MAX_DEGREE ? MAX_DEGREE : deg_reg;
      n = (kc_reg > MAX_KNOTS ? MAX_KNOTS : kc_reg) - p - 2;
      if ($urandom_range(0, 3) == 0) begin
         s.op = OP_WRITE;
         if (idx > 0 && idx < MAX_KNOTS - 1 && $urandom_range(0, 4) != 0) begin
            lo = knots[idx-1];
            hi = knots[idx+1];
            if ($urandom_range(0, 5) == 0) s.kval = 32'(lo);
            else if (hi >= lo && hi - lo < (64'sd1 <<< 31))
               s.kval = 32'(lo + longint'($urandom) % (hi - lo + 1));
            else s.kval = 32'(knots[idx]);
         end
      end else begin
         s.op = OP_EVAL;
         if (n >= 0 && $urandom_range(0, 9) < 7) begin
            lo = knot_at(p) - 64'sd65536;
            hi = knot_at(n + 1) + 64'sd65536;
            if (hi > lo && hi - lo < (64'sd1 <<< 31))
               s.pt = 32'(lo + longint'($urandom) % (hi - lo + 1));
         end
      end
      return s;
   endfunction

   stim_row_type directed [$];
   phase_type phases [$];

   initial begin
      stim_row_type s;
      longint acc;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_WRITE;
      req_bus.knot_index <= '0;
      req_bus.knot_value <= '0;
      req_bus.point <= '0;
      foreach (knots[i]) knots[i] = 0;

      for (int i = 0; i < 8; i++)
         directed.push_back('{OP_WRITE, KIDX_W'(i), 32'h0, 32'h0, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h0000_0000, 1, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h8000_0000, 1, 0});
      directed.push_back('{OP_WRITE, 63, 32'h7FFF_FFFF, 32'h0, 0, 0});
      directed.push_back('{OP_WRITE, 63, 32'h8000_0000, 32'h0, 0, 0});
      for (int i = 0; i < 8; i++)
         directed.push_back('{OP_WRITE, KIDX_W'(i), 32'(i << 16), 32'h0, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h7FFF_FFFF, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h0003_8000, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h0003_0000, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'h0005_0000, 0, 0});
      directed.push_back('{OP_EVAL, 0, 32'h0, 32'hFFFF_FFFF, 0, 0});

      phases = '{'{0, 2, 25}, '{1, 64, 30}, '{3, 20, 30}, '{5, 3, 10}, '{8, 64, 15},
                 '{15, 127, 10}, '{2, 10, 25}, '{15, 8, 10}, '{4, 12, 25}};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_beat(directed[i]);

      acc = -(64'sd20 <<< 16);
      for (int i = 0; i < MAX_KNOTS; i++) begin
         s = '{OP_WRITE, KIDX_W'(i), 32'(acc), 32'h0, 0, 0};
         send_beat(s);
         acc += $urandom_range(0, 3 << 16);
      end

      foreach (phases[ph]) begin
         settle_and_configure(phases[ph].deg, phases[ph].kc);
         if (ph == 2) long_hold = 1'b1;
         if (ph == phases.size() - 1) quiet = 1'b1;
         for (int k = 0; k < phases[ph].items; k++) send_beat(random_item());
      end
      req_bus.valid <= 1'b0;

      while (pending_basis.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_basis.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (1500) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      basis_beat_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_basis.size() == 0) begin
            $display("%0t: unexpected beat row %0d value %0d last %0b", $time,
                     rsp_bus.row, rsp_bus.basis_value, rsp_bus.last);
            errors++;
         end else begin
            e = pending_basis.pop_front();
            if (rsp_bus.row !== e.row) begin
               $display("%0t: row expected %0d actual %0d", $time, e.row, rsp_bus.row);
               errors++;
            end
            if (rsp_bus.basis_value !== e.value) begin
               $display("%0t: basis_value expected %0d actual %0d", $time, e.value,
                        rsp_bus.basis_value);
               errors++;
            end
            if (rsp_bus.last !== e.last) begin
               $display("%0t: last expected %0b actual %0b", $time, e.last, rsp_bus.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bbe_pkg.sv
hdl/bbe_ifs.sv
hdl/bbe_ram.sv
hdl/bbe_sdiv.sv
hdl/bspline_basis_evaluator.sv
verif/tb.sv
